// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/u2m_pkg.sv =====
// ----------------------------------------------------------------------------
// u2m_pkg
// Shared types and constants of the UTF-8 to UCS-2 MD5 block packer.
// ----------------------------------------------------------------------------
package u2m_pkg;

    localparam int MAX_CHARS_DEF = 27;
    localparam int STORE_WORDS   = 14;
    localparam int FIFO_DEPTH    = 4;

    localparam logic       OP_END     = 1'b1;
    localparam logic [7:0] LEAD2      = 8'hC0;
    localparam logic [7:0] LEAD3      = 8'hE0;
    localparam logic [7:0] LEAD4      = 8'hF0;
    localparam logic [15:0] PAD_UNIT  = 16'h0080;
    // low 16 bits of the lead-marker offsets of 2- and 3-byte sequences
    localparam logic [15:0] OFFSET2   = 16'h3080;
    localparam logic [15:0] OFFSET3   = 16'h2080;
    localparam logic [3:0] LEN_IDX    = 4'd14;
    localparam logic [3:0] LAST_IDX   = 4'd15;

    typedef struct packed {
        logic       op;
        logic [7:0] key_byte;
    } item_t;

    typedef struct packed {
        logic [3:0]  word_index;
        logic [31:0] word_value;
        logic        status;
        logic        last_word;
    } result_t;

    typedef enum logic [1:0] {
        CMD_UNIT,
        CMD_END,
        CMD_ERR
    } cmd_kind_t;

    // pos: unit position for CMD_UNIT, unit count for CMD_END
    typedef struct packed {
        cmd_kind_t   kind;
        logic [4:0]  pos;
        logic [15:0] unit;
    } cmd_t;

endpackage

// ===== hdl/u2m_front.sv =====
// ----------------------------------------------------------------------------
// u2m_front
// UTF-8 decoder: turns key bytes into unit, end-of-key and error commands.
// ----------------------------------------------------------------------------
module u2m_front #(
    parameter int MAX_CHARS = u2m_pkg::MAX_CHARS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u2m_pkg::item_t  item,
    input  logic            q_full,
    output logic            cmd_valid,
    output u2m_pkg::cmd_t   cmd
);

    logic [4:0]  count_reg,   count_next;
    logic [15:0] partial_reg, partial_next;
    logic [1:0]  pend_reg,    pend_next;
    logic [1:0]  seq_reg,     seq_next;
    logic        mal_reg,     mal_next;
    logic        accept;
    logic [15:0] shifted;
    logic [7:0]  b;

    assign accept  = push && !q_full;
    assign b       = item.key_byte;
    assign shifted = {partial_reg[9:0], 6'b0} + {8'b0, b};

    always_comb
    begin
        count_next   = count_reg;
        partial_next = partial_reg;
        pend_next    = pend_reg;
        seq_next     = seq_reg;
        mal_next     = mal_reg;
        cmd_valid    = 1'b0;
        cmd.kind     = u2m_pkg::CMD_UNIT;
        cmd.pos      = count_reg;
        cmd.unit     = {8'b0, b};
        if (accept)
        begin
            if (item.op == u2m_pkg::OP_END)
            begin
                cmd_valid    = 1'b1;
                cmd.kind     = (mal_reg || pend_reg != 2'd0) ? u2m_pkg::CMD_ERR
                                                             : u2m_pkg::CMD_END;
                count_next   = '0;
                partial_next = '0;
                pend_next    = '0;
                seq_next     = '0;
                mal_next     = 1'b0;
            end
            else if (!(mal_reg || count_reg >= 5'(MAX_CHARS)))
            begin
                if (pend_reg != 2'd0)
                begin
                    partial_next = shifted;
                    pend_next    = pend_reg - 2'd1;
                    if (pend_reg == 2'd1)
                    begin
                        cmd_valid  = 1'b1;
                        cmd.unit   = shifted - ((seq_reg == 2'd2) ? u2m_pkg::OFFSET3
                                                                  : u2m_pkg::OFFSET2);
                        count_next = count_reg + 5'd1;
                    end
                end
                else if (b inside {[u2m_pkg::LEAD4:8'hFF]})
                begin
                    mal_next = 1'b1;
                end
                else if (b inside {[u2m_pkg::LEAD3:8'hEF]})
                begin
                    partial_next = {8'b0, b};
                    pend_next    = 2'd2;
                    seq_next     = 2'd2;
                end
                else if (b inside {[u2m_pkg::LEAD2:8'hDF]})
                begin
                    partial_next = {8'b0, b};
                    pend_next    = 2'd1;
                    seq_next     = 2'd1;
                end
                else
                begin
                    cmd_valid  = 1'b1;
                    count_next = count_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            partial_reg <= '0;
            pend_reg    <= '0;
            seq_reg     <= '0;
            mal_reg     <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            partial_reg <= partial_next;
            pend_reg    <= pend_next;
            seq_reg     <= seq_next;
            mal_reg     <= mal_next;
        end
    end

endmodule

// ===== hdl/u2m_fifo.sv =====
// ----------------------------------------------------------------------------
// u2m_fifo
// Short command queue between decoder and packer.
// ----------------------------------------------------------------------------
module u2m_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  u2m_pkg::cmd_t  wr_cmd,
    input  logic           rd_en,
    output u2m_pkg::cmd_t  rd_cmd,
    output logic           full,
    output logic           empty
);

    localparam int PW = $clog2(u2m_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(u2m_pkg::FIFO_DEPTH + 1);

    u2m_pkg::cmd_t  mem [u2m_pkg::FIFO_DEPTH];
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_wr, do_rd;

    assign full   = (cnt_reg == CW'(u2m_pkg::FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = mem[rp_reg];

    always_comb
    begin
        wp_next  = do_wr ? PW'(wp_reg + 1'b1) : wp_reg;
        rp_next  = do_rd ? PW'(rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/u2m_packer.sv =====
// ----------------------------------------------------------------------------
// u2m_packer
// Packs units into the word store and streams finished blocks out.
// ----------------------------------------------------------------------------
module u2m_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  u2m_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    output u2m_pkg::result_t  result,
    output logic              empty,
    input  logic              pop
);

    localparam int SW = u2m_pkg::STORE_WORDS;

    logic [31:0] store_reg [SW];
    logic [31:0] store_next [SW];
    logic [31:0] emit_reg [SW];
    logic [31:0] emit_next [SW];
    logic        busy_reg, busy_next;
    logic        err_reg,  err_next;
    logic [3:0]  idx_reg,  idx_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        last_out;
    logic        free;
    logic [3:0]  wsel;

    assign last_out = err_reg || (idx_reg == u2m_pkg::LAST_IDX);
    assign free     = !busy_reg || (pop && last_out);
    assign cmd_pop  = cmd_valid && ((cmd.kind == u2m_pkg::CMD_UNIT) || free);
    assign wsel     = cmd.pos[4:1];
    assign empty    = !busy_reg;

    always_comb
    begin
        result.word_index = idx_reg;
        result.status     = err_reg;
        result.last_word  = last_out;
        if (err_reg || idx_reg == u2m_pkg::LAST_IDX)
        begin
            result.word_value = '0;
        end
        else if (idx_reg == u2m_pkg::LEN_IDX)
        begin
            result.word_value = {23'b0, cnt_reg, 4'b0};
        end
        else
        begin
            result.word_value = emit_reg[idx_reg];
        end
    end

    always_comb
    begin
        store_next = store_reg;
        emit_next  = emit_reg;
        busy_next  = busy_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        if (busy_reg && pop)
        begin
            if (last_out)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (cmd_pop)
        begin
            case (cmd.kind)
                u2m_pkg::CMD_UNIT:
                begin
                    if (cmd.pos[0])
                    begin
                        store_next[wsel][31:16] = cmd.unit;
                    end
                    else
                    begin
                        store_next[wsel][15:0] = cmd.unit;
                    end
                end
                u2m_pkg::CMD_END:
                begin
                    for (int i = 0; i < SW; i++)
                    begin
                        emit_next[i]  = store_reg[i];
                        store_next[i] = '0;
                        if (4'(i) == wsel)
                        begin
                            if (cmd.pos[0])
                            begin
                                emit_next[i][31:16] = u2m_pkg::PAD_UNIT;
                            end
                            else
                            begin
                                emit_next[i][15:0] = u2m_pkg::PAD_UNIT;
                            end
                        end
                    end
                    busy_next = 1'b1;
                    err_next  = 1'b0;
                    idx_next  = '0;
                    cnt_next  = cmd.pos;
                end
                u2m_pkg::CMD_ERR:
                begin
                    for (int i = 0; i < SW; i++)
                    begin
                        store_next[i] = '0;
                    end
                    busy_next = 1'b1;
                    err_next  = 1'b1;
                    idx_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        emit_reg <= emit_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SW; i++)
            begin
                store_reg[i] <= '0;
            end
            busy_reg <= 1'b0;
            err_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            store_reg <= store_next;
            busy_reg  <= busy_next;
            err_reg   <= err_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hdl/utf8_to_ucs2_md5_block_packer.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_md5_block_packer
// UTF-8 password bytes in, one padded 16-word MD5 message block out per key.
// ----------------------------------------------------------------------------
// Takes one key byte per cycle while full is low. The decoder folds 1-, 2-
// and 3-byte UTF-8 sequences into 16-bit units (continuation bytes unchecked)
// and keeps at most MAX_CHARS units; it pushes one command per finished unit
// or per end of key into a 4-entry queue. The packer writes units into a
// 14-word store, two per word, little-endian. On an end of key it copies
// the store, with the 0x80 pad unit merged in, into an output buffer and
// clears the store, so bytes of the next key keep flowing while the block
// drains. A good key yields words 0..15 (word 14 = units*16, word 15 = 0,
// last_word on 15); a four-byte lead or an end inside a sequence yields one
// result with status 1 and last_word set. Each end of key occupies the output
// buffer until its 16 (or 1) results are popped; a further end waits in the
// queue meanwhile, and the input side stalls only once that queue fills.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_md5_block_packer #(
    parameter int MAX_CHARS = u2m_pkg::MAX_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  u2m_pkg::item_t    item,
    output logic              empty,
    input  logic              pop,
    output u2m_pkg::result_t  result
);

`include "assert_macros.svh"

    logic           cmd_valid;
    u2m_pkg::cmd_t  cmd_in;
    u2m_pkg::cmd_t  cmd_out;
    logic           q_full;
    logic           q_empty;
    logic           cmd_pop;

    assign full = q_full;

    // decode front
    u2m_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .q_full    (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    // command queue
    u2m_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_valid),
        .wr_cmd (cmd_in),
        .rd_en  (cmd_pop),
        .rd_cmd (cmd_out),
        .full   (q_full),
        .empty  (q_empty)
    );

    // word store and block output
    u2m_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // error result is always a lone word 0
    `ASSERT_IMPL(a_err_single, !empty && result.status,
                 result.last_word && result.word_index == 4'd0 && result.word_value == '0)

    // word 15 closes a good block
    `ASSERT_IMPL(a_last_on_15, !empty && result.word_index == u2m_pkg::LAST_IDX,
                 result.last_word && !result.status)

    // block words come out in order without gaps
    `ASSERT_NEXT(a_idx_step, !empty && pop && !result.last_word,
                 !empty && result.word_index == $past(result.word_index) + 4'd1)

    // no command is lost: decoder never pushes into a full queue
    `ASSERT_IMPL(a_no_overflow, cmd_valid, !q_full)

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UCS-2 MD5 block packer.
// ----------------------------------------------------------------------------
// Key bytes and ends of key are pushed through the input queue port with
// random gaps. An in-bench scoreboard decodes the same bytes into 16-bit
// units, packs the expected MD5 block (or the single error word) and checks
// every popped word in order, field by field. The result side stalls at
// random as well. Coverage comes from a short directed section (empty key,
// odd and even unit counts, all lead byte classes, bad lead, end inside a
// sequence) and then random keys, most of them well formed, some long enough
// to hit the unit limit, some broken or pure noise.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_UNITS    = u2m_pkg::MAX_CHARS_DEF;
    localparam int ITEM_TARGET  = 370;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int BLOCK_WORDS  = 16;

    localparam logic OP_BYTE = 1'b0;
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_BAD  = 1'b1;

    // lead-marker offsets removed from the accumulated code point
    localparam logic [19:0] SEQ2_OFS = 20'h03080;
    localparam logic [19:0] SEQ3_OFS = 20'hE2080;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the packer state and queues the expected words.
    // ------------------------------------------------------------------------
    class block_scoreboard;
        logic [31:0]      key_words [u2m_pkg::STORE_WORDS];
        logic [4:0]       units_kept;
        logic [19:0]      code_acc;
        logic [1:0]       cont_left;
        logic [1:0]       seq_cont;
        bit               lead4_seen;
        u2m_pkg::result_t expected_words [$];
        int               fails;
        int               words_checked;
        int               good_keys;
        int               bad_keys;
        int               full_keys;

        function new();
            wipe();
            fails         = 0;
            words_checked = 0;
            good_keys     = 0;
            bad_keys      = 0;
            full_keys     = 0;
        endfunction

        function void wipe();
            foreach (key_words[i])
                key_words[i] = '0;
            units_kept = '0;
            code_acc   = '0;
            cont_left  = '0;
            seq_cont   = '0;
            lead4_seen = 1'b0;
        endfunction

        // even position -> low half, odd -> high half
        function void place(int pos, logic [15:0] u);
            int w;
            w = (pos >> 1) % u2m_pkg::STORE_WORDS;
            if (pos % 2)
                key_words[w][31:16] = u;
            else
                key_words[w][15:0] = u;
        endfunction

        function void keep_unit(logic [15:0] u);
            place(units_kept, u);
            units_kept++;
        endfunction

        // Takes one accepted word; returns 1 if it had any effect.
        function bit note_word(u2m_pkg::item_t w);
            u2m_pkg::result_t r;
            logic [19:0]      code;
            if (w.op == u2m_pkg::OP_END)
            begin
                if (lead4_seen || cont_left != 0)
                begin
                    r.word_index = '0;
                    r.word_value = '0;
                    r.status     = ST_BAD;
                    r.last_word  = 1'b1;
                    expected_words.push_back(r);
                    bad_keys++;
                end
                else
                begin
                    if (units_kept >= KEY_UNITS)
                        full_keys++;
                    place(units_kept, u2m_pkg::PAD_UNIT);
                    for (int i = 0; i < BLOCK_WORDS; i++)
                    begin
                        r.word_index = 4'(i);
                        if (i < u2m_pkg::STORE_WORDS)
                            r.word_value = key_words[i];
                        else if (4'(i) == u2m_pkg::LEN_IDX)
                            r.word_value = 32'(units_kept) << 4;
                        else
                            r.word_value = '0;
                        r.status    = ST_OK;
                        r.last_word = (4'(i) == u2m_pkg::LAST_IDX);
                        expected_words.push_back(r);
                    end
                    good_keys++;
                end
                wipe();
                return 1'b1;
            end
            // bad lead seen or block full: byte dropped
            if (lead4_seen || units_kept >= KEY_UNITS)
                return 1'b0;
            if (cont_left != 0)
            begin
                code_acc = (code_acc << 6) + w.key_byte;
                cont_left--;
                if (cont_left == 0)
                begin
                    code = code_acc - ((seq_cont == 2'd2) ? SEQ3_OFS : SEQ2_OFS);
                    keep_unit(code[15:0]);
                end
                return 1'b1;
            end
            if (w.key_byte >= u2m_pkg::LEAD4)
            begin
                lead4_seen = 1'b1;
            end
            else if (w.key_byte >= u2m_pkg::LEAD3)
            begin
                code_acc  = 20'(w.key_byte);
                cont_left = 2'd2;
                seq_cont  = 2'd2;
            end
            else if (w.key_byte >= u2m_pkg::LEAD2)
            begin
                code_acc  = 20'(w.key_byte);
                cont_left = 2'd1;
                seq_cont  = 2'd1;
            end
            else
            begin
                keep_unit(16'(w.key_byte));
            end
            return 1'b1;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t ns: word mismatch, %s: got 0x%0h, want 0x%0h",
                     $realtime, what, got, want);
            fails++;
        endtask

        task check_word(u2m_pkg::result_t r);
            u2m_pkg::result_t e;
            words_checked++;
            if (expected_words.size() == 0)
            begin
                report("no word pending", r.word_value, '0);
                return;
            end
            e = expected_words.pop_front();
            if (r.word_index !== e.word_index)
                report("word_index", r.word_index, e.word_index);
            if (r.word_value !== e.word_value)
                report("word_value", r.word_value, e.word_value);
            if (r.status !== e.status)
                report("status", r.status, e.status);
            if (r.last_word !== e.last_word)
                report("last_word", r.last_word, e.last_word);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    u2m_pkg::item_t   item;
    logic             empty;
    logic             pop;
    u2m_pkg::result_t result;

    block_scoreboard sb = new();

    bit calm;       // set in the last part of the run: no idling on either side
    int items_in;   // accepted words that changed the packer state
    int cycles;

    utf8_to_ucs2_md5_block_packer #(
        .MAX_CHARS(KEY_UNITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that outlives the limit has hung somewhere.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("utf8_to_ucs2_md5_block_packer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side. Drive on the falling edge, look at full on the rising edge.
    // An idle burst of random length may come before any word.
    // ------------------------------------------------------------------------
    task automatic send_word(u2m_pkg::item_t w);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
                item <= '{op: 1'($urandom_range(0, 1)), key_byte: 8'($urandom)};
            end
        end
        @(negedge clk);
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (sb.note_word(w))
            items_in++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word('{op: OP_BYTE, key_byte: b});
    endtask

    // key_byte is a don't-care on an end; keep it random so its bits move
    task automatic send_end();
        send_word('{op: u2m_pkg::OP_END, key_byte: 8'($urandom)});
    endtask

    // One well-formed UTF-8 sequence of 1, 2 or 3 bytes. Single bytes include
    // stray continuation bytes; continuation content is fully random since
    // the packer does not check it.
    task automatic send_unit(int len);
        case (len)
            1: send_byte(8'($urandom_range(8'h00, 8'hBF)));
            2:
            begin
                send_byte(8'($urandom_range(8'hC0, 8'hDF)));
                send_byte(8'($urandom));
            end
            default:
            begin
                send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                send_byte(8'($urandom));
                send_byte(8'($urandom));
            end
        endcase
    endtask

    // Random key: mostly well formed; some hit the unit limit and then get
    // junk that must be dropped, some carry a four-byte lead, some end inside
    // a sequence, and a few are pure noise.
    task automatic random_key();
        int flavor;
        int n;
        flavor = $urandom_range(0, 9);
        if ($urandom_range(0, 5) == 0)
            n = $urandom_range(KEY_UNITS - 3, KEY_UNITS + 4);
        else
            n = $urandom_range(0, 10);
        if (flavor == 9)
        begin
            repeat ($urandom_range(1, 16))
                send_byte(8'($urandom));
        end
        else
        begin
            repeat (n)
                send_unit($urandom_range(1, 3));
            if (flavor == 7)
            begin
                send_byte(8'($urandom_range(8'hF0, 8'hFF)));
                repeat ($urandom_range(0, 3))
                    send_unit($urandom_range(1, 3));
            end
            else if (flavor == 8)
            begin
                // cut the key short inside a multi-byte sequence
                if ($urandom_range(0, 1))
                    send_byte(8'($urandom_range(8'hC0, 8'hDF)));
                else
                begin
                    send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                    if ($urandom_range(0, 1))
                        send_byte(8'($urandom));
                end
            end
            // a bad lead after the block is full must be ignored
            if (n >= KEY_UNITS)
                send_byte(8'($urandom_range(8'hF0, 8'hFF)));
        end
        send_end();
    endtask

    // ------------------------------------------------------------------------
    // Result side: pop with random stall bursts, check on the rising edge.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        stall = 0;
        pop   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_word(result);
            @(negedge clk);
            if (!calm && stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 12) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        push     = 1'b0;
        item     = '0;
        calm     = 1'b0;
        items_in = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty key: pad lands in word 0 low half, length word is zero.
        // All-ones byte on the end word to show it is ignored.
        send_word('{op: u2m_pkg::OP_END, key_byte: 8'hFF});

        // Zero byte, top ASCII, stray continuations, 2- and 3-byte extremes
        // (the last one with out-of-range continuation bits). Eight units,
        // so the pad goes into a fresh word.
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hC2);
        send_byte(8'h80);
        send_byte(8'hDF);
        send_byte(8'hBF);
        send_byte(8'hE0);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'hEF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_end();

        // Odd unit count: pad in the high half of the last word.
        send_byte(8'h41);
        send_end();

        // Four-byte lead: single error word, later bytes dropped.
        send_byte(8'hF0);
        send_byte(8'h41);
        send_end();

        // End inside a three-byte sequence: error word as well.
        send_byte(8'hE2);
        send_byte(8'h82);
        send_end();

        // Random keys; the tail runs with no idling at all.
        while (items_in < ITEM_TARGET)
        begin
            calm = (items_in > ITEM_TARGET * 4 / 5);
            random_key();
        end
        @(negedge clk);
        push <= 1'b0;

        // Wait for the last block to drain, then watch for stray words.
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run summary: %0d key words accepted, %0d result words checked",
                 items_in, sb.words_checked);
        $display("  %0d padded blocks (%0d at the unit limit), %0d rejected keys",
                 sb.good_keys, sb.full_keys, sb.bad_keys);
        if (sb.fails == 0)
            $display("utf8_to_ucs2_md5_block_packer regression: pass");
        else
            $display("utf8_to_ucs2_md5_block_packer regression: fail");
        $finish;
    end

endmodule
